### rtl/core/vna_pkg.sv
// Shared types, constants and helpers for the vertex normal averager.
// Used by vertex_normal_averager; depends on nothing else.
package vna_pkg;

  localparam int VERTICES   = 1024;
  localparam int VADDR_W    = $clog2(VERTICES);
  localparam int COUNT_BITS = 8;
  localparam int SUM_W      = 24;
  localparam int UNIT_SHIFT = 14;

  localparam logic signed [SUM_W:0] SUM_MAX = 25'sd8388607;
  localparam logic signed [SUM_W:0] SUM_MIN = -25'sd8388608;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_TRI  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  typedef struct packed {
    logic        [1:0]  opcode;
    logic        [9:0]  vertex_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic        [9:0]  corner_a;
    logic        [9:0]  corner_b;
    logic        [9:0]  corner_c;
  } in_t;

  typedef struct packed {
    logic        [9:0]  out_vertex;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic        [7:0]  face_count;
    logic               unused;
  } out_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]    sx;
    logic signed [SUM_W-1:0]    sy;
    logic signed [SUM_W-1:0]    sz;
    logic        [COUNT_BITS-1:0] cnt;
  } acc_row_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    ST_RD_A, ST_RD_B, ST_RD_C, ST_RD_W,
    ST_CR_MUL, ST_CR_ACC, ST_MAG, ST_SHIFT,
    ST_SQ_MUL, ST_SQ_ACC, ST_SQ_SET, ST_SQRT,
    ST_DIV_SET, ST_DIV, ST_DIV_END,
    ST_AC_RD, ST_AC_WR,
    ST_RV_RD, ST_RV_SET, ST_RV_OUT
  } state_t;

  function automatic logic in_range(input logic [9:0] v);
    return int'(v) < VERTICES;
  endfunction

  // Add a normal component into a running sum, clamping at the sum limits.
  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                      input logic signed [15:0] n);
    logic signed [SUM_W:0] t;
    t = {s[SUM_W-1], s} + {{(SUM_W-15){n[15]}}, n};
    if (t > SUM_MAX) return SUM_MAX[SUM_W-1:0];
    if (t < SUM_MIN) return SUM_MIN[SUM_W-1:0];
    return t[SUM_W-1:0];
  endfunction

endpackage

### rtl/core/vertex_normal_averager.sv
// Top level of the vertex normal averager: sequencer, shared multiplier,
// square root and divider, position store and per-vertex sum store.
// Depends on vna_pkg.
//
// Usage. Words enter on in_valid/in_data and are taken at an edge where
// in_valid is high and in_stall is low. A load word writes one vertex
// position. A triangle word reads its three corners, forms the edge
// cross product with one 25x25 multiplier, scales it below 2^24 one bit
// per cycle, sums the squares, takes a bit-serial square root and
// divides each component by the length on a shared restoring divider,
// then adds the normal into the sum store for each corner, read then
// write. A face whose cross product is zero skips the normalization.
// A read word divides the vertex's sums by its face count in three
// 24-step divisions, skipped for a vertex with no faces; it yields one
// result word on out_valid/out_data and clears the vertex's sums.
// Load words and out-of-range triangles and opcode 3 give no result.
// The result sits in an output register: while out_stall holds it, the
// block keeps accepting and working on words and only waits when the next
// read result is ready to be loaded.
// After reset the sum store is cleared one vertex per cycle with in_stall
// high. Positions are not cleared and must be loaded first.
module vertex_normal_averager (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  vna_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output vna_pkg::out_t out_data
);

  localparam int AW = vna_pkg::VADDR_W;
  localparam int CW = vna_pkg::COUNT_BITS;
  localparam int SW = vna_pkg::SUM_W;

  vna_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   clr_addr_r, clr_addr_nxt;
  logic            out_valid_r, out_valid_nxt;
  vna_pkg::out_t   out_r;
  logic            out_load;

  // Word registers.
  logic [AW-1:0]   ca_r, cb_r, cc_r;
  logic [9:0]      vtx_r;
  logic            rd_bad_r;
  logic            rdop_r;
  logic [2:0]      step_r;

  // Geometry and normalization datapath.
  logic signed [15:0] pa_r [3];
  logic signed [16:0] e1_r [3];
  logic signed [16:0] e2_r [3];
  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] prod_r;
  logic signed [34:0] cr_r [3];
  logic [33:0]        mag_r [3];
  logic               neg_r [3];
  logic [49:0]        sq_r, vv_r, rt_r, bit_r;
  logic [50:0]        sq_try;
  logic               sq_ge;
  logic               mag_zero, mag_big;

  // Shared divider.
  logic [39:0]        rem_r, dsh_r;
  logic [23:0]        q_r;
  logic [4:0]         dcnt_r;
  logic signed [15:0] res_r [3];
  logic signed [15:0] q_signed;

  // Read path.
  logic signed [SW-1:0] sum_r [3];
  logic [CW-1:0]        cnt_r;
  logic [SW-1:0]        sum_abs;

  // Stores.
  logic [47:0]          pos_mem [vna_pkg::VERTICES];
  vna_pkg::acc_row_t    acc_mem [vna_pkg::VERTICES];
  logic [47:0]          pos_rd_r, pos_wdata;
  vna_pkg::acc_row_t    acc_rd_r, acc_wdata, acc_upd;
  logic                 pos_we, acc_we;
  logic [AW-1:0]        pos_waddr, pos_raddr, acc_waddr, acc_raddr, corner_sel;

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_rd_r <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    acc_rd_r <= acc_mem[acc_raddr];
  end

  always_comb begin
    case (step_r[1:0])
      2'd0:    corner_sel = ca_r;
      2'd1:    corner_sel = cb_r;
      default: corner_sel = cc_r;
    endcase
  end

  // Multiplier operand selection: cross-product terms, then squares.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == vna_pkg::ST_SQ_MUL) begin
      mul_a = {1'b0, mag_r[step_r[1:0]][23:0]};
      mul_b = {1'b0, mag_r[step_r[1:0]][23:0]};
    end else begin
      case (step_r)
        3'd0:    begin mul_a = 25'(e1_r[1]); mul_b = 25'(e2_r[2]); end
        3'd1:    begin mul_a = 25'(e1_r[2]); mul_b = 25'(e2_r[1]); end
        3'd2:    begin mul_a = 25'(e1_r[2]); mul_b = 25'(e2_r[0]); end
        3'd3:    begin mul_a = 25'(e1_r[0]); mul_b = 25'(e2_r[2]); end
        3'd4:    begin mul_a = 25'(e1_r[0]); mul_b = 25'(e2_r[1]); end
        default: begin mul_a = 25'(e1_r[1]); mul_b = 25'(e2_r[0]); end
      endcase
    end
  end

  assign mag_zero = (mag_r[0] == '0) && (mag_r[1] == '0) && (mag_r[2] == '0);
  assign mag_big  = (mag_r[0][33:24] != '0) || (mag_r[1][33:24] != '0) ||
                    (mag_r[2][33:24] != '0);
  assign sq_try   = {1'b0, rt_r} + {1'b0, bit_r};
  assign sq_ge    = {1'b0, vv_r} >= sq_try;
  assign q_signed = neg_r[step_r[1:0]] ? -16'(q_r) : 16'(q_r);
  assign sum_abs  = sum_r[step_r[1:0]][SW-1] ? SW'(-sum_r[step_r[1:0]])
                                             : SW'(sum_r[step_r[1:0]]);

  // Sum store update for one corner; a full count leaves the row alone.
  always_comb begin
    acc_upd     = acc_rd_r;
    acc_upd.sx  = vna_pkg::sat_add(acc_rd_r.sx, res_r[0]);
    acc_upd.sy  = vna_pkg::sat_add(acc_rd_r.sy, res_r[1]);
    acc_upd.sz  = vna_pkg::sat_add(acc_rd_r.sz, res_r[2]);
    acc_upd.cnt = acc_rd_r.cnt + CW'(1);
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    in_stall      = 1'b1;
    pos_we        = 1'b0;
    pos_waddr     = AW'(in_data.vertex_index);
    pos_wdata     = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
    pos_raddr     = ca_r;
    acc_we        = 1'b0;
    acc_waddr     = corner_sel;
    acc_wdata     = acc_upd;
    acc_raddr     = corner_sel;
    out_load      = 1'b0;
    unique case (state_r)
      vna_pkg::ST_CLEAR: begin
        acc_we       = 1'b1;
        acc_waddr    = clr_addr_r;
        acc_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(vna_pkg::VERTICES - 1)) begin
          state_nxt = vna_pkg::ST_IDLE;
        end
      end
      vna_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_data.opcode)
            vna_pkg::OP_LOAD: pos_we = vna_pkg::in_range(in_data.vertex_index);
            vna_pkg::OP_TRI: begin
              if (vna_pkg::in_range(in_data.corner_a) &&
                  vna_pkg::in_range(in_data.corner_b) &&
                  vna_pkg::in_range(in_data.corner_c)) begin
                state_nxt = vna_pkg::ST_RD_A;
              end
            end
            vna_pkg::OP_READ: state_nxt = vna_pkg::ST_RV_RD;
            default: ;
          endcase
        end
      end
      vna_pkg::ST_RD_A: begin
        pos_raddr = ca_r;
        state_nxt = vna_pkg::ST_RD_B;
      end
      vna_pkg::ST_RD_B: begin
        pos_raddr = cb_r;
        state_nxt = vna_pkg::ST_RD_C;
      end
      vna_pkg::ST_RD_C: begin
        pos_raddr = cc_r;
        state_nxt = vna_pkg::ST_RD_W;
      end
      vna_pkg::ST_RD_W:   state_nxt = vna_pkg::ST_CR_MUL;
      vna_pkg::ST_CR_MUL: state_nxt = vna_pkg::ST_CR_ACC;
      vna_pkg::ST_CR_ACC: state_nxt = (step_r == 3'd5) ? vna_pkg::ST_MAG : vna_pkg::ST_CR_MUL;
      vna_pkg::ST_MAG:    state_nxt = vna_pkg::ST_SHIFT;
      vna_pkg::ST_SHIFT: begin
        if (mag_zero) begin
          state_nxt = vna_pkg::ST_AC_RD;
        end else if (!mag_big) begin
          state_nxt = vna_pkg::ST_SQ_MUL;
        end
      end
      vna_pkg::ST_SQ_MUL: state_nxt = vna_pkg::ST_SQ_ACC;
      vna_pkg::ST_SQ_ACC: state_nxt = (step_r == 3'd2) ? vna_pkg::ST_SQ_SET : vna_pkg::ST_SQ_MUL;
      vna_pkg::ST_SQ_SET: state_nxt = vna_pkg::ST_SQRT;
      vna_pkg::ST_SQRT: begin
        if (bit_r[0]) begin
          state_nxt = vna_pkg::ST_DIV_SET;
        end
      end
      vna_pkg::ST_DIV_SET: state_nxt = vna_pkg::ST_DIV;
      vna_pkg::ST_DIV: begin
        if (dcnt_r == '0) begin
          state_nxt = vna_pkg::ST_DIV_END;
        end
      end
      vna_pkg::ST_DIV_END: begin
        if (step_r == 3'd2) begin
          state_nxt = rdop_r ? vna_pkg::ST_RV_OUT : vna_pkg::ST_AC_RD;
        end else begin
          state_nxt = vna_pkg::ST_DIV_SET;
        end
      end
      vna_pkg::ST_AC_RD: state_nxt = vna_pkg::ST_AC_WR;
      vna_pkg::ST_AC_WR: begin
        acc_we    = (acc_rd_r.cnt != {CW{1'b1}});
        state_nxt = (step_r == 3'd2) ? vna_pkg::ST_IDLE : vna_pkg::ST_AC_RD;
      end
      vna_pkg::ST_RV_RD: begin
        acc_raddr = AW'(vtx_r);
        state_nxt = vna_pkg::ST_RV_SET;
      end
      vna_pkg::ST_RV_SET: begin
        state_nxt = (rd_bad_r || acc_rd_r.cnt == '0) ? vna_pkg::ST_RV_OUT
                                                     : vna_pkg::ST_DIV_SET;
      end
      vna_pkg::ST_RV_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          acc_we    = !rd_bad_r;
          acc_waddr = AW'(vtx_r);
          acc_wdata = '0;
          state_nxt = vna_pkg::ST_IDLE;
        end
      end
      default: state_nxt = vna_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vna_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers, advanced by the sequencer state.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.out_vertex <= vtx_r;
      out_r.normal_x   <= res_r[0];
      out_r.normal_y   <= res_r[1];
      out_r.normal_z   <= res_r[2];
      out_r.face_count <= 8'(cnt_r);
      out_r.unused     <= (cnt_r == '0);
    end
    case (state_r)
      vna_pkg::ST_IDLE: begin
        ca_r     <= AW'(in_data.corner_a);
        cb_r     <= AW'(in_data.corner_b);
        cc_r     <= AW'(in_data.corner_c);
        vtx_r    <= in_data.vertex_index;
        rd_bad_r <= !vna_pkg::in_range(in_data.vertex_index);
        rdop_r   <= (in_data.opcode == vna_pkg::OP_READ);
        step_r   <= '0;
      end
      vna_pkg::ST_RD_B: begin
        for (int i = 0; i < 3; i++) begin
          pa_r[i] <= pos_rd_r[16*i +: 16];
        end
      end
      vna_pkg::ST_RD_C: begin
        for (int i = 0; i < 3; i++) begin
          e1_r[i] <= 17'(signed'(pos_rd_r[16*i +: 16])) - 17'(pa_r[i]);
        end
      end
      vna_pkg::ST_RD_W: begin
        for (int i = 0; i < 3; i++) begin
          e2_r[i] <= 17'(signed'(pos_rd_r[16*i +: 16])) - 17'(pa_r[i]);
        end
      end
      vna_pkg::ST_CR_MUL, vna_pkg::ST_SQ_MUL: prod_r <= mul_a * mul_b;
      vna_pkg::ST_CR_ACC: begin
        if (!step_r[0]) begin
          cr_r[step_r[2:1]] <= prod_r[34:0];
        end else begin
          cr_r[step_r[2:1]] <= cr_r[step_r[2:1]] - prod_r[34:0];
        end
        step_r <= step_r + 3'd1;
      end
      vna_pkg::ST_MAG: begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= cr_r[i][34];
          mag_r[i] <= cr_r[i][34] ? 34'(-cr_r[i]) : 34'(cr_r[i]);
        end
        step_r <= '0;
        sq_r   <= '0;
      end
      vna_pkg::ST_SHIFT: begin
        // The same right shift on all three keeps their ratios.
        if (mag_zero) begin
          for (int i = 0; i < 3; i++) begin
            res_r[i] <= '0;
          end
        end else if (mag_big) begin
          for (int i = 0; i < 3; i++) begin
            mag_r[i] <= mag_r[i] >> 1;
          end
        end
      end
      vna_pkg::ST_SQ_ACC: begin
        sq_r   <= sq_r + prod_r[49:0];
        step_r <= step_r + 3'd1;
      end
      vna_pkg::ST_SQ_SET: begin
        vv_r   <= sq_r;
        rt_r   <= '0;
        bit_r  <= {2'b01, 48'b0};
        step_r <= '0;
      end
      vna_pkg::ST_SQRT: begin
        if (sq_ge) begin
          vv_r <= vv_r - sq_try[49:0];
          rt_r <= (rt_r >> 1) + bit_r;
        end else begin
          rt_r <= rt_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      vna_pkg::ST_DIV_SET: begin
        q_r <= '0;
        if (rdop_r) begin
          rem_r  <= 40'(sum_abs) + 40'(cnt_r >> 1);
          dsh_r  <= 40'(cnt_r) << 23;
          dcnt_r <= 5'd23;
          neg_r[step_r[1:0]] <= sum_r[step_r[1:0]][SW-1];
        end else begin
          rem_r  <= (40'(mag_r[step_r[1:0]][23:0]) << vna_pkg::UNIT_SHIFT) +
                    40'(rt_r[24:1]);
          dsh_r  <= 40'(rt_r[24:0]) << vna_pkg::UNIT_SHIFT;
          dcnt_r <= 5'(vna_pkg::UNIT_SHIFT);
        end
      end
      vna_pkg::ST_DIV: begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          q_r   <= {q_r[22:0], 1'b1};
        end else begin
          q_r   <= {q_r[22:0], 1'b0};
        end
        dsh_r  <= dsh_r >> 1;
        dcnt_r <= dcnt_r - 5'd1;
      end
      vna_pkg::ST_DIV_END: begin
        res_r[step_r[1:0]] <= q_signed;
        step_r <= (step_r == 3'd2) ? 3'd0 : step_r + 3'd1;
      end
      vna_pkg::ST_AC_WR: step_r <= step_r + 3'd1;
      vna_pkg::ST_RV_SET: begin
        sum_r[0] <= acc_rd_r.sx;
        sum_r[1] <= acc_rd_r.sy;
        sum_r[2] <= acc_rd_r.sz;
        cnt_r    <= rd_bad_r ? '0 : acc_rd_r.cnt;
        step_r   <= '0;
        for (int i = 0; i < 3; i++) begin
          res_r[i] <= '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A new result appears only when the read sequence hands it over.
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == vna_pkg::ST_RV_OUT))
    else $error("result raised outside the read hand-over");

  // The square root walks a single bit down through the word.
  a_sqrt_bit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == vna_pkg::ST_SQRT |-> $onehot(bit_r))
    else $error("square root bit lost");

  // A face normal is of unit length at most before it is accumulated.
  a_unit_normal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == vna_pkg::ST_AC_RD |->
      (res_r[0] <= 16'sd16384 && res_r[0] >= -16'sd16384 &&
       res_r[1] <= 16'sd16384 && res_r[1] >= -16'sd16384 &&
       res_r[2] <= 16'sd16384 && res_r[2] >= -16'sd16384))
    else $error("face normal beyond unit length");

endmodule

### test/vna_checker.sv
// Checker for the vertex normal averager: watches both channels, predicts each
// read result from its own copy of the position and sum stores, and compares.
// Depends on vna_pkg.
module vna_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  vna_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  vna_pkg::out_t out_data,
  output int            fail_count,
  output int            pending
);

  logic signed [15:0] pos_mem [vna_pkg::VERTICES][3];
  logic signed [23:0] acc_x [vna_pkg::VERTICES];
  logic signed [23:0] acc_y [vna_pkg::VERTICES];
  logic signed [23:0] acc_z [vna_pkg::VERTICES];
  int unsigned        acc_n [vna_pkg::VERTICES];
  vna_pkg::out_t      normal_q [$];

  assign pending = normal_q.size();

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [23:0] clamp_add(input logic signed [23:0] s,
                                                   input longint n);
    longint t;
    t = longint'(s) + n;
    if (t > 8388607) t = 8388607;
    if (t < -8388608) t = -8388608;
    return t[23:0];
  endfunction

  function automatic logic signed [15:0] round_avg(input logic signed [23:0] s,
                                                   input int unsigned c);
    longint m, q;
    m = (s < 0) ? -longint'(s) : longint'(s);
    q = (m + c / 2) / c;
    return (s < 0) ? 16'(-q) : 16'(q);
  endfunction

  task automatic add_face(input int a, input int b, input int c);
    longint e1[3], e2[3], cr[3], nrm[3];
    longint unsigned m[3], mx, sq, len;
    int s, v, k;
    int vs[3];
    mx = 0;
    sq = 0;
    s = 0;
    for (k = 0; k < 3; k++) begin
      e1[k] = longint'(pos_mem[b][k]) - longint'(pos_mem[a][k]);
      e2[k] = longint'(pos_mem[c][k]) - longint'(pos_mem[a][k]);
      nrm[k] = 0;
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    for (k = 0; k < 3; k++) begin
      m[k] = cr[k] < 0 ? -cr[k] : cr[k];
      if (m[k] > mx) mx = m[k];
    end
    if (mx != 0) begin
      while ((mx >> s) >= (64'd1 << 24)) s++;
      for (k = 0; k < 3; k++) begin
        m[k] >>= s;
        sq += m[k] * m[k];
      end
      len = int_sqrt(sq);
      if (len != 0)
        for (k = 0; k < 3; k++) begin
          nrm[k] = longint'((m[k] * 16384 + len / 2) / len);
          if (cr[k] < 0) nrm[k] = -nrm[k];
        end
    end
    vs[0] = a;
    vs[1] = b;
    vs[2] = c;
    // A repeated corner is accumulated once per appearance.
    for (k = 0; k < 3; k++) begin
      v = vs[k];
      if (acc_n[v] < (1 << vna_pkg::COUNT_BITS) - 1) begin
        acc_n[v]++;
        acc_x[v] = clamp_add(acc_x[v], nrm[0]);
        acc_y[v] = clamp_add(acc_y[v], nrm[1]);
        acc_z[v] = clamp_add(acc_z[v], nrm[2]);
      end
    end
  endtask

  always @(posedge clk) begin
    int v;
    vna_pkg::out_t e, got;
    if (!rst_n) begin
      fail_count <= 0;
      normal_q.delete();
      for (int i = 0; i < vna_pkg::VERTICES; i++) begin
        acc_x[i] = 0;
        acc_y[i] = 0;
        acc_z[i] = 0;
        acc_n[i] = 0;
        for (int k = 0; k < 3; k++) pos_mem[i][k] = 0;
      end
    end else begin
      if (in_valid && !in_stall) begin
        case (in_data.opcode)
          vna_pkg::OP_LOAD: begin
            v = in_data.vertex_index;
            if (v < vna_pkg::VERTICES) begin
              pos_mem[v][0] = in_data.pos_x;
              pos_mem[v][1] = in_data.pos_y;
              pos_mem[v][2] = in_data.pos_z;
            end
          end
          vna_pkg::OP_TRI: begin
            if (in_data.corner_a < vna_pkg::VERTICES &&
                in_data.corner_b < vna_pkg::VERTICES &&
                in_data.corner_c < vna_pkg::VERTICES)
              add_face(in_data.corner_a, in_data.corner_b, in_data.corner_c);
          end
          vna_pkg::OP_READ: begin
            v = in_data.vertex_index;
            e = '0;
            e.out_vertex = in_data.vertex_index;
            if (v < vna_pkg::VERTICES && acc_n[v] != 0) begin
              e.normal_x = round_avg(acc_x[v], acc_n[v]);
              e.normal_y = round_avg(acc_y[v], acc_n[v]);
              e.normal_z = round_avg(acc_z[v], acc_n[v]);
              e.face_count = acc_n[v][7:0];
            end else begin
              e.unused = 1'b1;
            end
            if (v < vna_pkg::VERTICES) begin
              acc_x[v] = 0;
              acc_y[v] = 0;
              acc_z[v] = 0;
              acc_n[v] = 0;
            end
            normal_q = {normal_q, e};
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (normal_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          e = normal_q.pop_front();
          if (got !== e) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, e, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### test/tb.sv
// Testbench top for the vertex normal averager: clock, reset, stimulus,
// idling phases and verdict. Depends on vna_pkg, vna_checker and the block.
module tb;

  localparam int IN_W = $bits(vna_pkg::in_t);

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  vna_pkg::in_t   in_data;
  logic           out_valid;
  logic           out_stall;
  vna_pkg::out_t  out_data;
  int             fail_count;
  int             pending;

  // Idle percentages for the sender and the receiver; the stimulus sets them
  // per phase. A long hold-off forces the receiver to stall outright.
  int    send_idle;
  int    recv_idle;
  int    hold_cycles;
  longint cycle_count;

  // Vertices whose positions were loaded; triangles use only these so that
  // no corner ever reads an unwritten position.
  bit    loaded [vna_pkg::VERTICES];
  int    loaded_list [$];

  vertex_normal_averager uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  vna_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random, or solidly during a hold-off.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  // Watchdog: the limit allows for every item being as slow as a triangle
  // under heavy idling, several times over.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 3000000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Offers one word: random idle cycles first, then valid stays high with a
  // steady payload until the block takes it. Valid is dropped by the next
  // idle cycle or by drain.
  task automatic send_word(input vna_pkg::in_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic load_vertex(input int v, input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z);
    vna_pkg::in_t w;
    w = vna_pkg::in_t'(IN_W'({$urandom, $urandom, $urandom}));
    w.opcode = vna_pkg::OP_LOAD;
    w.vertex_index = 10'(v);
    w.pos_x = x;
    w.pos_y = y;
    w.pos_z = z;
    if (!loaded[v]) loaded_list = {loaded_list, v};
    loaded[v] = 1'b1;
    send_word(w);
  endtask

  task automatic add_triangle(input int a, input int b, input int c);
    vna_pkg::in_t w;
    w = vna_pkg::in_t'(IN_W'({$urandom, $urandom, $urandom}));
    w.opcode = vna_pkg::OP_TRI;
    w.corner_a = 10'(a);
    w.corner_b = 10'(b);
    w.corner_c = 10'(c);
    send_word(w);
  endtask

  task automatic read_vertex(input int v);
    vna_pkg::in_t w;
    w = vna_pkg::in_t'(IN_W'({$urandom, $urandom, $urandom}));
    w.opcode = vna_pkg::OP_READ;
    w.vertex_index = 10'(v);
    send_word(w);
  endtask

  function automatic int pick_loaded();
    return loaded_list[$urandom_range(loaded_list.size() - 1)];
  endfunction

  // Mostly small meshes: vertices mostly from indices 0 to 15, a quarter
  // from the whole index space, loaded, linked by triangles, then read back.
  task automatic random_item();
    int r, a;
    vna_pkg::in_t w;
    r = $urandom_range(99);
    if (r < 20 || loaded_list.size() < 3) begin
      a = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(15);
      load_vertex(a, 16'($urandom), 16'($urandom), 16'($urandom));
    end else if (r < 65) begin
      add_triangle(pick_loaded(), pick_loaded(), pick_loaded());
    end else if (r < 92) begin
      read_vertex(($urandom_range(9) == 0) ? $urandom_range(1023) : pick_loaded());
    end else begin
      // Noise: opcode 3 with random fields; it must give no result.
      w = vna_pkg::in_t'(IN_W'({$urandom, $urandom, $urandom}));
      w.opcode = vna_pkg::OP_NOP;
      send_word(w);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    int i;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    send_idle   = 0;
    recv_idle   = 0;
    hold_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme positions, a regular face, a degenerate face, a
    // repeated corner, a read of a vertex with no faces, an index at the top
    // of the range, and opcode 3.
    load_vertex(0, 16'sh0000, 16'sh0000, 16'sh0000);
    load_vertex(1, 16'sh7fff, 16'sh0000, 16'sh0000);
    load_vertex(2, 16'sh0000, 16'sh7fff, 16'sh0000);
    load_vertex(3, 16'sh8000, 16'sh8000, 16'sh8000);
    load_vertex(1023, 16'sh7fff, 16'sh8000, 16'sh7fff);
    add_triangle(0, 1, 2);
    add_triangle(0, 2, 1);
    add_triangle(0, 0, 1);
    add_triangle(1, 1, 1);
    add_triangle(3, 1023, 2);
    add_triangle(1023, 3, 1);
    read_vertex(0);
    read_vertex(1);
    read_vertex(0);
    read_vertex(3);
    read_vertex(1023);
    read_vertex(2);
    read_vertex(500);
    begin
      vna_pkg::in_t w;
      w = '1;
      send_word(w);
    end
    drain();

    // Full count: vertex 1 appears twice in each of 130 faces, past the 255
    // count limit; the faces are degenerate and add zero normals.
    for (i = 0; i < 130; i++) add_triangle(1, 2, 1);
    read_vertex(1);
    read_vertex(2);
    drain();

    // Random phases with different idling.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 85; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 85; end
        default: begin send_idle = 37; recv_idle = 37; end
      endcase
      for (i = 0; i < 440; i++) begin
        if (ph == 2 && i == 100) hold_cycles = 3000;
        random_item();
      end
      // The sender pauses until every expected word has come.
      drain();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/core/vna_pkg.sv
rtl/core/vertex_normal_averager.sv
test/vna_checker.sv
test/tb.sv
